// ===== rtl/rse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'b1;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd70;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd600;
  localparam logic [15:0] COUNT_MAX        = 16'hffff;

  // bit i set when transition code i is a legal quadrature step
  localparam logic [15:0] VALID_CODES = 16'h6996;
  localparam logic [7:0]  HIST_CW     = 8'h2b;
  localparam logic [7:0]  HIST_CCW    = 8'h17;

  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_CW    = 2'd1;
  localparam logic [1:0] ROT_CCW   = 2'd2;

  localparam logic [1:0] PRESS_NONE  = 2'd0;
  localparam logic [1:0] PRESS_SHORT = 2'd1;
  localparam logic [1:0] PRESS_LONG  = 2'd2;

  localparam logic [1:0] SET_ON    = 2'd0;
  localparam logic [1:0] SET_OFF   = 2'd1;
  localparam logic [1:0] SET_PULSE = 2'd2;

  localparam logic [9:0] ON_RESET    = 10'd50;
  localparam logic [9:0] OFF_RESET   = 10'd80;
  localparam logic [6:0] PULSE_RESET = 7'd4;

  localparam logic [10:0] ON_MAX    = 11'd999;
  localparam logic [10:0] OFF_MAX   = 11'd999;
  localparam logic [10:0] PULSE_MAX = 11'd99;

  typedef struct packed {
    logic [1:0] rot;
    logic [1:0] press;
  } ev_t;

endpackage

`default_nettype wire

// ===== rtl/rse_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rse_in_if;
  logic valid;
  logic ready;
  logic enc_clk_level;
  logic enc_dt_level;
  logic button_level;

  modport source (output valid, output enc_clk_level, output enc_dt_level,
                  output button_level, input ready);
  modport sink (input valid, input enc_clk_level, input enc_dt_level,
                input button_level, output ready);
endinterface

interface rse_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] on_duration;
  logic [9:0] off_duration;
  logic [6:0] pulse_count;
  logic [1:0] selected_setting;
  logic [1:0] digit_index;
  logic [1:0] rotation_event;
  logic [1:0] press_event;

  modport source (output valid, output on_duration, output off_duration,
                  output pulse_count, output selected_setting, output digit_index,
                  output rotation_event, output press_event, input ready);
  modport sink (input valid, input on_duration, input off_duration,
                input pulse_count, input selected_setting, input digit_index,
                input rotation_event, input press_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/rse_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rse_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rse_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rse_pkg::CfgDataW-1:0]    cfg_wdata_i,
  rse_in_if.sink                          in_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output rse_pkg::ev_t                    ev_o
);
  import rse_pkg::*;

  logic [15:0] debounce_q, long_q;
  logic [3:0]  code_q, code_d;
  logic [7:0]  hist_q, hist_d;
  logic        btn_q, btn_d;
  logic [15:0] edge_ms_q, edge_ms_d;
  logic [15:0] press_ms_q, press_ms_d;
  logic [15:0] edge_inc, press_inc;
  logic        counted;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  assign edge_inc  = (edge_ms_q == COUNT_MAX) ? edge_ms_q : edge_ms_q + 16'd1;
  assign press_inc = (press_ms_q == COUNT_MAX) ? press_ms_q : press_ms_q + 16'd1;
  assign counted   = edge_inc > debounce_q;

  always_comb begin
    code_d     = {code_q[1:0], ~in_i.enc_dt_level, ~in_i.enc_clk_level};
    hist_d     = hist_q;
    btn_d      = in_i.button_level;
    edge_ms_d  = edge_inc;
    press_ms_d = press_inc;
    ev_o.rot   = ROT_NONE;
    ev_o.press = PRESS_NONE;
    if (VALID_CODES[code_d]) begin
      hist_d = {hist_q[3:0], code_d};
      if (hist_d == HIST_CW) begin
        ev_o.rot = ROT_CW;
      end else if (hist_d == HIST_CCW) begin
        ev_o.rot = ROT_CCW;
      end
    end
    if (in_i.button_level != btn_q) begin
      if (counted) begin
        if (in_i.button_level) begin
          ev_o.press = (press_inc > long_q) ? PRESS_LONG : PRESS_SHORT;
        end else begin
          press_ms_d = '0;
        end
      end
      edge_ms_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      long_q     <= LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   debounce_q <= cfg_wdata_i;
        REG_LONG_PRESS: long_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q     <= '0;
      hist_q     <= '0;
      btn_q      <= 1'b1;
      edge_ms_q  <= '0;
      press_ms_q <= '0;
    end else if (push_o) begin
      code_q     <= code_d;
      hist_q     <= hist_d;
      btn_q      <= btn_d;
      edge_ms_q  <= edge_ms_d;
      press_ms_q <= press_ms_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rse_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rse_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rse_pkg::ev_t  ev_i,
  input  logic          pop_i,
  output rse_pkg::ev_t  ev_o,
  output logic          empty_o,
  output logic          full_o
);
  import rse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ev_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign ev_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rse_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rse_pkg::ev_t  ev_i,
  output logic          pop_o,
  rse_out_if.source     out_o
);
  import rse_pkg::*;

  logic [9:0]  on_q, on_d;
  logic [9:0]  off_q, off_d;
  logic [6:0]  pulse_q, pulse_d;
  logic [1:0]  set_q, set_d;
  logic [1:0]  dig_q, dig_d;
  logic        ovalid_q;
  logic [10:0] weight, cur, vmax, sum, adj;
  logic        up;

  assign pop_o = !q_empty_i && (!ovalid_q || out_o.ready);
  assign up    = (ev_i.rot == ROT_CW);

  always_comb begin
    case (dig_q)
      2'd0:    weight = 11'd1;
      2'd1:    weight = 11'd10;
      2'd2:    weight = 11'd100;
      default: weight = 11'd1000;
    endcase
    case (set_q)
      SET_ON:    begin cur = {1'b0, on_q};     vmax = ON_MAX;    end
      SET_OFF:   begin cur = {1'b0, off_q};    vmax = OFF_MAX;   end
      SET_PULSE: begin cur = {4'b0, pulse_q};  vmax = PULSE_MAX; end
      default:   begin cur = '0;               vmax = '0;        end
    endcase
    sum = cur + weight;
    if (up) begin
      adj = (sum > vmax) ? vmax : sum;
    end else begin
      adj = (cur < weight) ? '0 : cur - weight;
    end
  end

  always_comb begin
    on_d    = on_q;
    off_d   = off_q;
    pulse_d = pulse_q;
    set_d   = set_q;
    dig_d   = dig_q;
    if (ev_i.rot != ROT_NONE) begin
      case (set_q)
        SET_ON:    on_d    = adj[9:0];
        SET_OFF:   off_d   = adj[9:0];
        SET_PULSE: pulse_d = adj[6:0];
        default: ;
      endcase
    end
    case (ev_i.press)
      PRESS_LONG: begin
        set_d = (set_q == SET_ON) ? SET_OFF : ((set_q == SET_OFF) ? SET_PULSE : SET_ON);
        dig_d = '0;
      end
      PRESS_SHORT: begin
        if (set_q == SET_PULSE) begin
          dig_d = {1'b0, ~dig_q[0]};
        end else begin
          case (dig_q)
            2'd0:    dig_d = 2'd1;
            2'd1:    dig_d = 2'd2;
            2'd2:    dig_d = 2'd0;
            default: dig_d = 2'd1;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= ON_RESET;
      off_q    <= OFF_RESET;
      pulse_q  <= PULSE_RESET;
      set_q    <= SET_ON;
      dig_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        on_q    <= on_d;
        off_q   <= off_d;
        pulse_q <= pulse_d;
        set_q   <= set_d;
        dig_q   <= dig_d;
      end
      if (pop_o) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_o.on_duration      <= on_d;
      out_o.off_duration     <= off_d;
      out_o.pulse_count      <= pulse_d;
      out_o.selected_setting <= set_d;
      out_o.digit_index      <= dig_d;
      out_o.rotation_event   <= ev_i.rot;
      out_o.press_event      <= ev_i.press;
    end
  end

  assign out_o.valid = ovalid_q;

endmodule

`default_nettype wire

// ===== rtl/rotary_encoder_setting_editor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Setting editor for a rotary encoder with push button, fed one pin sample per
// millisecond tick. It takes one sample word per clock cycle unless the event
// queue is full, and returns one result word per sample, in order. The front
// end decodes encoder steps and debounces the button, the back end applies
// steps and presses to the on time, off time and pulse count settings; a small
// event queue of QueueDepth entries sits between them. With an idle output the
// event enters the queue when its sample is accepted and moves into the output
// register in the following cycle, where the result becomes valid. While the
// output is held, up to QueueDepth further samples are taken before the input
// stalls. The user must see that debounce_ms (index 0) and long_press_ms
// (index 1) are written through the cfg port only while no sample is in
// flight; the block itself does not enforce this.
module rotary_encoder_setting_editor #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rse_pkg::CfgDataW-1:0]  cfg_wdata_i,
  rse_in_if.sink                        in_i,
  rse_out_if.source                     out_o
);
  import rse_pkg::*;

  logic push, pop, q_empty, q_full;
  ev_t  ev_in, ev_out;

  rse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .ev_o        (ev_in)
  );

  rse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ev_i    (ev_in),
    .pop_i   (pop),
    .ev_o    (ev_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  rse_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .ev_i      (ev_out),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/rotary_encoder_setting_editor_test.sv =====
`timescale 1ns / 1ps

module rotary_encoder_setting_editor_test;
  import rse_pkg::*;

  localparam logic [15:0] LEGAL_CODE_MASK = 16'b0110_1001_1001_0110;
  localparam logic [7:0]  RIGHT_HIST      = 8'h2b;
  localparam logic [7:0]  LEFT_HIST       = 8'h17;
  localparam logic [15:0] SAT_MAX         = 16'hffff;
  localparam int          ON_LIMIT        = 999;
  localparam int          OFF_LIMIT       = 999;
  localparam int          PULSE_LIMIT     = 99;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          ROW_COUNT       = 22;

  typedef struct packed {
    logic [9:0] on_ms;
    logic [9:0] off_ms;
    logic [6:0] pulses;
    logic [1:0] setting;
    logic [1:0] digit;
    logic [1:0] rot;
    logic [1:0] press;
  } editor_word_t;

  typedef struct packed {
    logic         clk_lvl;
    logic         dt_lvl;
    logic         btn_lvl;
    logic         typed;
    editor_word_t want;
  } script_row_t;

  localparam editor_word_t NO_WORD = '0;
  localparam editor_word_t WANT_AFTER_RESET = '{on_ms: 10'd50, off_ms: 10'd80, pulses: 7'd4,
      setting: SET_ON, digit: 2'd0, rot: ROT_NONE, press: PRESS_NONE};
  localparam editor_word_t WANT_FIRST_RIGHT = '{on_ms: 10'd51, off_ms: 10'd80, pulses: 7'd4,
      setting: SET_ON, digit: 2'd0, rot: ROT_CW, press: PRESS_NONE};
  localparam editor_word_t WANT_FLOOR = '{on_ms: 10'd0, off_ms: 10'd80, pulses: 7'd4,
      setting: SET_ON, digit: 2'd2, rot: ROT_CCW, press: PRESS_NONE};
  localparam editor_word_t WANT_TURN_AND_LONG = '{on_ms: 10'd100, off_ms: 10'd80, pulses: 7'd4,
      setting: SET_OFF, digit: 2'd0, rot: ROT_CW, press: PRESS_LONG};

  // runs with debounce 0 and long press 3
  localparam script_row_t SCRIPT [ROW_COUNT] = '{
    '{1'b1, 1'b1, 1'b1, 1'b1, WANT_AFTER_RESET},
    '{1'b1, 1'b0, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 1'b0, 1'b1, 1'b1, WANT_FIRST_RIGHT},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 1'b0, 1'b1, 1'b1, WANT_FLOOR},
    '{1'b1, 1'b0, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WORD},
    '{1'b1, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 1'b0, 1'b1, 1'b1, WANT_TURN_AND_LONG},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 1'b0, 1'b1, 1'b0, NO_WORD},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WORD}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rse_in_if  sample_if ();
  rse_out_if result_if ();

  rotary_encoder_setting_editor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (sample_if),
    .out_o       (result_if)
  );

  always #10 clk_i = ~clk_i;

  // editor model state
  logic [15:0] debounce_cfg;
  logic [15:0] long_cfg;
  logic [3:0]  code_q;
  logic [7:0]  hist_q;
  logic        btn_q;
  logic [15:0] since_edge_q;
  logic [15:0] since_press_q;
  logic [9:0]  on_q;
  logic [9:0]  off_q;
  logic [6:0]  pulse_q;
  logic [1:0]  setting_q;
  logic [1:0]  digit_q;

  editor_word_t expected_words [$];
  int  word_errors = 0;
  int  sent_count = 0;
  int  rx_hold_req = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  pin_clk = 1'b1;
  bit  pin_dt = 1'b1;
  bit  pin_btn = 1'b1;

  function automatic int bump(input int v, input int w, input bit up, input int top);
    if (up) begin
      return (v + w > top) ? top : v + w;
    end
    return (v < w) ? 0 : v - w;
  endfunction

  function automatic void reset_editor();
    debounce_cfg  = 16'd70;
    long_cfg      = 16'd600;
    code_q        = '0;
    hist_q        = '0;
    btn_q         = 1'b1;
    since_edge_q  = '0;
    since_press_q = '0;
    on_q          = 10'd50;
    off_q         = 10'd80;
    pulse_q       = 7'd4;
    setting_q     = SET_ON;
    digit_q       = 2'd0;
  endfunction

  function automatic editor_word_t step_editor(input bit clk_lvl, input bit dt_lvl,
                                               input bit btn_lvl);
    logic [1:0]   rot;
    logic [1:0]   press;
    int           weight;
    editor_word_t w;
    rot   = ROT_NONE;
    press = PRESS_NONE;
    code_q = {code_q[1:0], ~dt_lvl, ~clk_lvl};
    if (LEGAL_CODE_MASK[code_q]) begin
      hist_q = {hist_q[3:0], code_q};
      if (hist_q == RIGHT_HIST) begin
        rot = ROT_CW;
      end else if (hist_q == LEFT_HIST) begin
        rot = ROT_CCW;
      end
    end
    if (since_edge_q != SAT_MAX) since_edge_q = since_edge_q + 16'd1;
    if (since_press_q != SAT_MAX) since_press_q = since_press_q + 16'd1;
    if (btn_lvl != btn_q) begin
      if (since_edge_q > debounce_cfg) begin
        if (btn_lvl) begin
          press = (since_press_q > long_cfg) ? PRESS_LONG : PRESS_SHORT;
        end else begin
          since_press_q = '0;
        end
      end
      since_edge_q = '0;
    end
    btn_q = btn_lvl;
    if (rot != ROT_NONE) begin
      weight = 1;
      repeat (digit_q) weight = weight * 10;
      case (setting_q)
        SET_ON: begin
          on_q = 10'(bump(on_q, weight, rot == ROT_CW, ON_LIMIT));
        end
        SET_OFF: begin
          off_q = 10'(bump(off_q, weight, rot == ROT_CW, OFF_LIMIT));
        end
        SET_PULSE: begin
          pulse_q = 7'(bump(pulse_q, weight, rot == ROT_CW, PULSE_LIMIT));
        end
        default: ;
      endcase
    end
    if (press == PRESS_LONG) begin
      setting_q = (setting_q >= SET_PULSE) ? SET_ON : setting_q + 2'd1;
      digit_q   = 2'd0;
    end else if (press == PRESS_SHORT) begin
      digit_q = 2'((int'(digit_q) + 1) % ((setting_q == SET_PULSE) ? 2 : 3));
    end
    w.on_ms   = on_q;
    w.off_ms  = off_q;
    w.pulses  = pulse_q;
    w.setting = setting_q;
    w.digit   = digit_q;
    w.rot     = rot;
    w.press   = press;
    return w;
  endfunction

  function automatic string word_text(input editor_word_t w);
    return $sformatf("on=%0d off=%0d pulses=%0d setting=%0d digit=%0d rot=%0d press=%0d",
                     w.on_ms, w.off_ms, w.pulses, w.setting, w.digit, w.rot, w.press);
  endfunction

  task automatic check_word();
    editor_word_t got;
    editor_word_t exp_word;
    got.on_ms   = result_if.on_duration;
    got.off_ms  = result_if.off_duration;
    got.pulses  = result_if.pulse_count;
    got.setting = result_if.selected_setting;
    got.digit   = result_if.digit_index;
    got.rot     = result_if.rotation_event;
    got.press   = result_if.press_event;
    if (expected_words.size() == 0) begin
      word_errors++;
      if (word_errors <= 10) $display("unexpected word at %0t: %s", $realtime, word_text(got));
    end else begin
      exp_word = expected_words.pop_front();
      if (got.on_ms !== exp_word.on_ms || got.off_ms !== exp_word.off_ms ||
          got.pulses !== exp_word.pulses || got.setting !== exp_word.setting ||
          got.digit !== exp_word.digit || got.rot !== exp_word.rot ||
          got.press !== exp_word.press) begin
        word_errors++;
        if (word_errors <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", word_text(exp_word));
          $display("  actual   %s", word_text(got));
        end
      end
    end
  endtask

  task automatic send_sample(input bit c, input bit d, input bit b, input bit has_want,
                             input editor_word_t want);
    int           gap;
    editor_word_t predicted;
    if (sent_count % 50 == 0) begin
      tx_idle_on = $urandom_range(0, 2) != 0;
      rx_idle_on = $urandom_range(0, 2) != 0;
    end
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid         <= 1'b1;
    sample_if.enc_clk_level <= c;
    sample_if.enc_dt_level  <= d;
    sample_if.button_level  <= b;
    pin_clk = c;
    pin_dt  = d;
    pin_btn = b;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    predicted = step_editor(c, d, b);
    expected_words.push_back(has_want ? want : predicted);
    sent_count++;
  endtask

  task automatic put(input bit c, input bit d, input bit b);
    send_sample(c, d, b, 1'b0, NO_WORD);
  endtask

  task automatic rest_samples(input int n);
    repeat (n) put(1'b1, 1'b1, pin_btn);
  endtask

  // one detent, pins active low, optional release on the step that fires
  task automatic turn_knob(input bit cw, input bit let_go);
    logic [1:0] path [4];
    int         k;
    int         extra;
    if (cw) path = '{2'b10, 2'b11, 2'b01, 2'b00};
    else path = '{2'b01, 2'b11, 2'b10, 2'b00};
    if (!(pin_clk && pin_dt)) put(1'b1, 1'b1, pin_btn);
    for (k = 0; k < 4; k++) begin
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (extra) put(~path[k][0], ~path[k][1], pin_btn);
      put(~path[k][0], ~path[k][1], (let_go && k == 1) ? 1'b1 : pin_btn);
    end
  endtask

  task automatic press_button(input int right_pct);
    int deb_span;
    int long_span;
    int hold;
    deb_span  = (debounce_cfg > 90) ? 4 : int'(debounce_cfg);
    long_span = (long_cfg > 700) ? 30 : int'(long_cfg);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        put(1'b1, 1'b1, 1'b0);
        put(1'b1, 1'b1, 1'b1);
      end
    end
    put(1'b1, 1'b1, 1'b0);
    case ($urandom_range(0, 2))
      0: hold = $urandom_range(0, deb_span + 2);
      1: hold = deb_span + $urandom_range(0, long_span);
      default: hold = deb_span + long_span + $urandom_range(0, 3);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) turn_knob($urandom_range(0, 99) < right_pct, 1'b0);
    end
    rest_samples(hold);
    if ($urandom_range(0, 3) == 0) begin
      turn_knob($urandom_range(0, 99) < right_pct, 1'b1);
    end else begin
      put(1'b1, 1'b1, 1'b1);
    end
    rest_samples($urandom_range(0, deb_span + 2));
  endtask

  task automatic scramble_pins();
    repeat ($urandom_range(1, 6)) begin
      put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
          ($urandom_range(0, 3) == 0) ? ~pin_btn : pin_btn);
    end
  endtask

  task automatic run_phase(input int n, input int right_pct);
    int stop_at;
    int pick;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        turn_knob($urandom_range(0, 99) < right_pct, 1'b0);
        if ($urandom_range(0, 1) == 0) rest_samples($urandom_range(0, 3));
      end else if (pick < 75) begin
        press_button(right_pct);
      end else if (pick < 88) begin
        rest_samples($urandom_range(1, 4));
      end else begin
        scramble_pins();
      end
    end
  endtask

  task automatic wait_all_words();
    sample_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [15:0] debounce, input logic [15:0] long_press);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEBOUNCE;
    cfg_wdata_i <= debounce;
    @(posedge clk_i);
    debounce_cfg = debounce;
    cfg_idx_i   <= REG_LONG_PRESS;
    cfg_wdata_i <= long_press;
    @(posedge clk_i);
    long_cfg = long_press;
    cfg_we_i <= 1'b0;
  endtask

  // receiver with random stalls and one long hold-off on request
  initial begin
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        check_word();
        wait_left = rx_idle_on ? $urandom_range(0, 18) : 0;
      end
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    int stalled;
    stalled = 0;
    forever begin
      @(posedge clk_i);
      if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
          (result_if.valid === 1'b1 && result_if.ready === 1'b1)) begin
        stalled = 0;
      end else begin
        stalled++;
        if (stalled >= STALL_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    int p;
    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= REG_DEBOUNCE;
    cfg_wdata_i             <= '0;
    sample_if.valid         <= 1'b0;
    sample_if.enc_clk_level <= 1'b1;
    sample_if.enc_dt_level  <= 1'b1;
    sample_if.button_level  <= 1'b1;
    reset_editor();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limits(16'd0, 16'd3);
    for (int i = 0; i < ROW_COUNT; i++) begin
      send_sample(SCRIPT[i].clk_lvl, SCRIPT[i].dt_lvl, SCRIPT[i].btn_lvl, SCRIPT[i].typed,
                  SCRIPT[i].want);
    end
    wait_all_words();

    // receiver holds off while samples keep coming
    write_limits(16'd3, 16'd10);
    tx_idle_on  = 1'b0;
    rx_hold_req = 300;
    run_phase(200, 70);
    wait_all_words();

    write_limits(16'd0, 16'd0);
    run_phase(200, 50);
    wait_all_words();

    write_limits(16'hffff, 16'd6);
    run_phase(200, 50);
    wait_all_words();

    write_limits(16'd5, 16'hffff);
    run_phase(200, 30);
    wait_all_words();

    write_limits(16'd70, 16'd600);
    run_phase(150, 50);
    wait_all_words();

    write_limits(16'd1, 16'd1);
    run_phase(200, 80);
    wait_all_words();

    for (p = 0; p < 3; p++) begin
      write_limits(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)));
      run_phase(150, $urandom_range(10, 90));
      wait_all_words();
    end

    repeat (4) @(posedge clk_i);
    if (word_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
